// ----- src/lfsp_pkg.sv -----
// Shared types and constants for the line follower steering block.
// Register map, error codes, stage-to-stage structs. No dependencies.
package lfsp_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned INTEG_W   = 24;
  localparam int unsigned TURN_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_LIMIT = 3'd4;

  typedef logic signed [3:0] err_t;

  localparam err_t ERR_CENTRE  = 4'sd0;
  localparam err_t ERR_LEFT_1  = -4'sd2;
  localparam err_t ERR_RIGHT_1 = 4'sd2;
  localparam err_t ERR_LEFT_2  = -4'sd3;
  localparam err_t ERR_RIGHT_2 = 4'sd3;
  localparam err_t ERR_LEFT_3  = -4'sd5;
  localparam err_t ERR_RIGHT_3 = 4'sd5;

  localparam logic [3:0] BLACK_STOP = 4'd6;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = 24'sh7FFFFF;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = 24'sh800000;
  localparam logic signed [TURN_W-1:0]  TURN_MAX  = 16'sh7FFF;
  localparam logic signed [TURN_W-1:0]  TURN_MIN  = 16'sh8000;

  typedef struct packed {
    logic signed [7:0] base_speed;
    logic [7:0]        gain_p;
    logic [7:0]        gain_i;
    logic [7:0]        gain_d;
    logic [7:0]        lost_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    base_speed: 8'sd20,
    gain_p:     8'd3,
    gain_i:     8'd0,
    gain_d:     8'd3,
    lost_limit: 8'd5
  };

  typedef struct packed {
    logic [3:0] black;
    err_t       err;
  } decode_t;

  typedef struct packed {
    logic                      stop;
    err_t                      err;
    logic signed [4:0]         diff;
    logic signed [INTEG_W-1:0] acc;
  } mid_t;

endpackage

// ----- src/lfsp_decode.sv -----
// Sensor byte decoder: black sensor count and priority error map.
// Purely combinational; uses lfsp_pkg.
module lfsp_decode (
  input  logic [7:0]        sensor_i,
  input  lfsp_pkg::err_t    held_err_i,
  output lfsp_pkg::decode_t dec_o
);
  import lfsp_pkg::*;

  always_comb begin
    dec_o.black = '0;
    for (int i = 0; i < 8; i++) begin
      dec_o.black = dec_o.black + {3'b000, ~sensor_i[i]};
    end
    if (!sensor_i[4] || !sensor_i[3]) begin
      dec_o.err = ERR_CENTRE;
    end else if (!sensor_i[5]) begin
      dec_o.err = ERR_LEFT_1;
    end else if (!sensor_i[2]) begin
      dec_o.err = ERR_RIGHT_1;
    end else if (!sensor_i[6]) begin
      dec_o.err = ERR_LEFT_2;
    end else if (!sensor_i[1]) begin
      dec_o.err = ERR_RIGHT_2;
    end else if (!sensor_i[7]) begin
      dec_o.err = ERR_LEFT_3;
    end else if (!sensor_i[0]) begin
      dec_o.err = ERR_RIGHT_3;
    end else begin
      dec_o.err = held_err_i;
    end
  end

endmodule

// ----- src/lfsp_track.sv -----
// Tracking stage: lost-line counting, stop decision, error and integral state.
// Uses lfsp_pkg and lfsp_decode; feeds the PID stage through mid_t.
module lfsp_track (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     sensor_i,
  input  logic [7:0]     lost_limit_i,
  output logic           mid_valid_o,
  input  logic           mid_ready_i,
  output lfsp_pkg::mid_t mid_o
);
  import lfsp_pkg::*;

  decode_t                   dec;
  err_t                      held_q, last_valid_q, prev_q;
  logic [7:0]                lost_ticks_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic                      mid_valid_q;
  mid_t                      mid_q;

  logic                      fire, lost, stop;
  err_t                      err;
  logic signed [INTEG_W:0]   acc_ext;
  logic signed [INTEG_W-1:0] acc;

  lfsp_decode u_decode (
    .sensor_i  (sensor_i),
    .held_err_i(held_q),
    .dec_o     (dec)
  );

  assign in_ready_o  = !mid_valid_q || mid_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign mid_valid_o = mid_valid_q;
  assign mid_o       = mid_q;

  always_comb begin
    lost    = (dec.black == 4'd0);
    stop    = (dec.black >= BLACK_STOP) || (lost && (lost_ticks_q >= lost_limit_i));
    err     = lost ? last_valid_q : dec.err;
    acc_ext = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(err);
    if (acc_ext[INTEG_W] != acc_ext[INTEG_W-1]) begin
      acc = acc_ext[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      acc = acc_ext[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= ERR_CENTRE;
      last_valid_q <= ERR_CENTRE;
      prev_q       <= ERR_CENTRE;
      lost_ticks_q <= '0;
      integ_q      <= '0;
      mid_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        mid_valid_q <= in_valid_i;
      end
      if (fire) begin
        if (stop) begin
          held_q <= ERR_CENTRE;
        end else begin
          held_q  <= err;
          prev_q  <= err;
          integ_q <= acc;
          if (lost) begin
            lost_ticks_q <= lost_ticks_q + 8'd1;
          end else begin
            lost_ticks_q <= '0;
            last_valid_q <= err;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      mid_q.stop <= stop;
      mid_q.err  <= err;
      mid_q.diff <= 5'(err) - 5'(prev_q);
      mid_q.acc  <= acc;
    end
  end

  a_stop_clears_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && stop |=> held_q == ERR_CENTRE)
    else $error("held error not cleared on stop");

  a_lost_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !stop && lost |=> lost_ticks_q == $past(lost_ticks_q) + 8'd1)
    else $error("lost tick count did not advance");

  a_line_clears_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !lost && !stop |=> lost_ticks_q == 8'd0)
    else $error("lost tick count not cleared on a valid line");

  a_stop_keeps_integ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && stop |=> $stable(integ_q) && $stable(prev_q))
    else $error("PID state changed on stop");

endmodule

// ----- src/lfsp_pid.sv -----
// PID stage: three gain products, sum, saturation and the result register.
// Uses lfsp_pkg; takes mid_t from the tracking stage.
module lfsp_pid (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lfsp_pkg::cfg_t           cfg_i,
  input  logic                     mid_valid_i,
  output logic                     mid_ready_o,
  input  lfsp_pkg::mid_t           mid_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     stopped_o,
  output logic signed [7:0]        drive_speed_o,
  output logic signed [lfsp_pkg::TURN_W-1:0] turn_value_o
);
  import lfsp_pkg::*;

  logic signed [12:0]        prod_p;
  logic signed [INTEG_W+8:0] prod_i;
  logic signed [13:0]        prod_d;
  logic signed [INTEG_W+10:0] sum;
  logic signed [TURN_W-1:0]  turn;

  logic                      out_valid_q, stopped_q;
  logic signed [7:0]         drive_q;
  logic signed [TURN_W-1:0]  turn_q;

  assign mid_ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    prod_p = $signed({1'b0, cfg_i.gain_p}) * mid_i.err;
    prod_i = $signed({1'b0, cfg_i.gain_i}) * mid_i.acc;
    prod_d = $signed({1'b0, cfg_i.gain_d}) * mid_i.diff;
    sum    = (INTEG_W+11)'(prod_p) + (INTEG_W+11)'(prod_i) + (INTEG_W+11)'(prod_d);
    if (sum > (INTEG_W+11)'(TURN_MAX)) begin
      turn = TURN_MAX;
    end else if (sum < (INTEG_W+11)'(TURN_MIN)) begin
      turn = TURN_MIN;
    end else begin
      turn = sum[TURN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (mid_ready_o) begin
      out_valid_q <= mid_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_valid_i && mid_ready_o) begin
      stopped_q <= mid_i.stop;
      drive_q   <= mid_i.stop ? 8'sd0 : cfg_i.base_speed;
      turn_q    <= mid_i.stop ? '0 : turn;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign stopped_o     = stopped_q;
  assign drive_speed_o = drive_q;
  assign turn_value_o  = turn_q;

endmodule

// ----- src/line_follow_steering_pid.sv -----
// Top level of the eight-sensor line follower with positional PID steering.
// Holds the configuration registers and input register; uses lfsp_pkg,
// lfsp_track and lfsp_pid.
//
// One sensor byte is taken per clock unless the output stalls, and every item
// gives exactly one result: stopped, drive speed and a saturated turn value. An
// accepted item passes through the input register and the tracking stage
// register into the result register; the unstalled rate is one item per cycle,
// set by the error and integral update in the tracking stage, whose state feeds
// the next item directly. The three gain multiplies sit in a stage of their own
// after it. Configuration writes are always taken and must be made while no item
// is in flight. No state needs a clearing pass after reset.
module line_follow_steering_pid (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lfsp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [7:0]                         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         sensor_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               stopped_o,
  output logic signed [7:0]                  drive_speed_o,
  output logic signed [lfsp_pkg::TURN_W-1:0] turn_value_o
);
  import lfsp_pkg::*;

  cfg_t       cfg_q;
  logic       in_valid_q;
  logic [7:0] sensor_q;
  logic       track_ready;
  logic       mid_valid, mid_ready;
  mid_t       mid;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !in_valid_q || track_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= CFG_RESET;
      in_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_BASE_SPEED: cfg_q.base_speed <= cfg_data_i;
          REG_GAIN_P:     cfg_q.gain_p     <= cfg_data_i;
          REG_GAIN_I:     cfg_q.gain_i     <= cfg_data_i;
          REG_GAIN_D:     cfg_q.gain_d     <= cfg_data_i;
          REG_LOST_LIMIT: cfg_q.lost_limit <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sensor_q <= sensor_byte_i;
    end
  end

  lfsp_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (track_ready),
    .sensor_i    (sensor_q),
    .lost_limit_i(cfg_q.lost_limit),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_o       (mid)
  );

  lfsp_pid u_pid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .mid_valid_i  (mid_valid),
    .mid_ready_o  (mid_ready),
    .mid_i        (mid),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .stopped_o    (stopped_o),
    .drive_speed_o(drive_speed_o),
    .turn_value_o (turn_value_o)
  );

endmodule
